// ===== rtl/srrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_pkg: shared types for the semaphore round-robin scheduler
// Operation codes, slot status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srrs_pkg;

  typedef enum logic [2:0] {
    OP_CREATE    = 3'd0,
    OP_TERMINATE = 3'd1,
    OP_SEM_INIT  = 3'd2,
    OP_WAIT      = 3'd3,
    OP_SIGNAL    = 3'd4,
    OP_TICK      = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    PS_EMPTY   = 2'd0,
    PS_ACTIVE  = 2'd1,
    PS_BLOCKED = 2'd2,
    PS_TERM    = 2'd3
  } pstat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_LINK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_step;
    logic link_load;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_scan;
    logic need_link;
    logic scan_done;
  } sts_t;

endpackage

// ===== rtl/srrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/srrs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_ctrl: scheduler controller
// Sequences accept, execute, ring scan, queue link load and result transfer.
// ----------------------------------------------------------------------------
module srrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output srrs_pkg::cmd_t cmd,
  input  srrs_pkg::sts_t sts
);

  srrs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srrs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      srrs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = srrs_pkg::S_EXEC;
        end
      end
      srrs_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_scan) begin
          state_nxt = srrs_pkg::S_SCAN;
        end else if (sts.need_link) begin
          state_nxt = srrs_pkg::S_LINK;
        end else begin
          state_nxt = srrs_pkg::S_FINISH;
        end
      end
      srrs_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = srrs_pkg::S_FINISH;
        end
      end
      srrs_pkg::S_LINK: begin
        cmd.link_load = 1'b1;
        state_nxt     = srrs_pkg::S_FINISH;
      end
      srrs_pkg::S_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = srrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srrs_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != srrs_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/srrs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_dp: scheduler datapath
// Process table, ring state, semaphore counts and wait queues, ring scan and
// the result register.
// ----------------------------------------------------------------------------
module srrs_dp #(
  parameter int NUM_PROCS  = 16,
  parameter int NUM_SEMS   = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  srrs_pkg::cmd_t cmd,
  output srrs_pkg::sts_t sts,
  input  logic [2:0]     in_operation,
  input  logic [1:0]     in_sem_id,
  input  logic [7:0]     in_init_value,
  input  logic           in_os_busy,
  output logic [3:0]     out_current_process,
  output logic           out_switched,
  output logic           out_halted,
  output logic [3:0]     out_created_slot,
  output logic           out_table_full
);

  localparam int IdxW = $clog2(NUM_PROCS);
  localparam int CntW = $clog2(NUM_PROCS + 1);
  localparam int SemW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int SatW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  // latched item
  logic [2:0]      op_r, op_nxt;
  logic [1:0]      sid_r, sid_nxt;
  logic [7:0]      ival_r, ival_nxt;
  logic            busy_r, busy_nxt;
  logic [IdxW-1:0] before_r, before_nxt;
  logic [IdxW-1:0] created_r, created_nxt;
  logic            full_r, full_nxt;

  // scheduler state
  logic [IdxW-1:0] running_r, running_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            halt_r, halt_nxt;
  logic            halt_on_none_r, halt_on_none_nxt;

  logic [COUNT_BITS-1:0] sem_val_r [NUM_SEMS];
  logic [COUNT_BITS-1:0] sem_val_nxt [NUM_SEMS];
  logic                  q_empty_r [NUM_SEMS];
  logic                  q_empty_nxt [NUM_SEMS];
  logic [IdxW-1:0]       q_head_r [NUM_SEMS];
  logic [IdxW-1:0]       q_head_nxt [NUM_SEMS];
  logic [IdxW-1:0]       q_tail_r [NUM_SEMS];
  logic [IdxW-1:0]       q_tail_nxt [NUM_SEMS];

  // ring scan
  logic [IdxW-1:0] iss_s_r, iss_s_nxt;
  logic [CntW-1:0] iss_left_r, iss_left_nxt;
  logic            chk_v_r, chk_v_nxt;
  logic [IdxW-1:0] chk_s_r, chk_s_nxt;

  // result register
  logic [3:0] res_cur_r;
  logic       res_sw_r;
  logic       res_halt_r;
  logic [3:0] res_created_r;
  logic       res_full_r;

  // memories
  logic            st_we;
  logic [IdxW-1:0] st_waddr;
  logic [1:0]      st_wdata;
  logic [IdxW-1:0] st_raddr;
  logic [1:0]      st_rdata;
  logic            lk_we;
  logic [IdxW-1:0] lk_waddr;
  logic [IdxW-1:0] lk_wdata;
  logic [IdxW-1:0] lk_rdata;

  logic [SemW-1:0] sem_idx;
  logic            sem_ok;
  logic            cur_ok;
  logic            scan_found;
  logic            scan_none;
  logic [SatW-1:0] ival_ext;
  logic [COUNT_BITS-1:0] init_sat;
  logic [IdxW-1:0] head_cur;
  logic [IdxW-1:0] ring_first;
  logic [IdxW-1:0] iss_s_adv;

  srrs_ram #(.WIDTH(2), .DEPTH(NUM_PROCS)) u_status_ram (
    .clk     (clk),
    .wr_en   (st_we),
    .wr_addr (st_waddr),
    .wr_data (st_wdata),
    .rd_addr (st_raddr),
    .rd_data (st_rdata)
  );

  srrs_ram #(.WIDTH(IdxW), .DEPTH(NUM_PROCS)) u_link_ram (
    .clk     (clk),
    .wr_en   (lk_we),
    .wr_addr (lk_waddr),
    .wr_data (lk_wdata),
    .rd_addr (head_cur),
    .rd_data (lk_rdata)
  );

  assign sem_idx  = SemW'({{SemW{1'b0}}, sid_r});
  assign sem_ok   = (32'(sid_r) < 32'(NUM_SEMS));
  assign cur_ok   = (count_r != '0) && (st_rdata == srrs_pkg::PS_ACTIVE);
  assign head_cur = q_head_r[sem_idx];
  assign ival_ext = SatW'(ival_r);
  assign init_sat = (ival_ext > SatW'(CountMax)) ? CountMax : COUNT_BITS'(ival_ext);

  // slot after the running one, wrapping at the end of the ring
  assign ring_first = (CntW'(running_r) == count_r - CntW'(1)) ? '0
                      : running_r + IdxW'(1);
  assign iss_s_adv  = (CntW'(iss_s_r) == count_r - CntW'(1)) ? '0
                      : iss_s_r + IdxW'(1);

  assign scan_found = chk_v_r && (st_rdata == srrs_pkg::PS_ACTIVE);
  assign scan_none  = !chk_v_r && (iss_left_r == '0);
  assign st_raddr   = cmd.scan_step ? iss_s_r : running_r;

  always_comb begin
    op_nxt           = op_r;
    sid_nxt          = sid_r;
    ival_nxt         = ival_r;
    busy_nxt         = busy_r;
    before_nxt       = before_r;
    created_nxt      = created_r;
    full_nxt         = full_r;
    running_nxt      = running_r;
    count_nxt        = count_r;
    halt_nxt         = halt_r;
    halt_on_none_nxt = halt_on_none_r;
    sem_val_nxt      = sem_val_r;
    q_empty_nxt      = q_empty_r;
    q_head_nxt       = q_head_r;
    q_tail_nxt       = q_tail_r;
    iss_s_nxt        = iss_s_r;
    iss_left_nxt     = iss_left_r;
    chk_v_nxt        = chk_v_r;
    chk_s_nxt        = chk_s_r;
    st_we            = 1'b0;
    st_waddr         = running_r;
    st_wdata         = srrs_pkg::PS_ACTIVE;
    lk_we            = 1'b0;
    lk_waddr         = q_tail_r[sem_idx];
    lk_wdata         = running_r;
    sts              = '0;

    if (cmd.accept) begin
      op_nxt      = in_operation;
      sid_nxt     = in_sem_id;
      ival_nxt    = in_init_value;
      busy_nxt    = in_os_busy;
      before_nxt  = running_r;
      created_nxt = '0;
      full_nxt    = 1'b0;
    end

    if (cmd.exec && !halt_r) begin
      case (op_r)
        srrs_pkg::OP_CREATE: begin
          if (count_r < CntW'(NUM_PROCS)) begin
            st_we       = 1'b1;
            st_waddr    = IdxW'(count_r);
            st_wdata    = srrs_pkg::PS_ACTIVE;
            created_nxt = IdxW'(count_r);
            count_nxt   = count_r + CntW'(1);
          end else begin
            full_nxt = 1'b1;
          end
        end
        srrs_pkg::OP_TERMINATE: begin
          if (cur_ok) begin
            st_we    = 1'b1;
            st_wdata = srrs_pkg::PS_TERM;
          end
        end
        srrs_pkg::OP_SEM_INIT: begin
          if (sem_ok) begin
            sem_val_nxt[sem_idx] = init_sat;
            q_empty_nxt[sem_idx] = 1'b1;
          end
        end
        srrs_pkg::OP_WAIT: begin
          if (sem_ok) begin
            if (sem_val_r[sem_idx] != '0) begin
              sem_val_nxt[sem_idx] = sem_val_r[sem_idx] - COUNT_BITS'(1);
            end else if (cur_ok) begin
              // block current, append to the queue, then look for the next one
              st_we    = 1'b1;
              st_wdata = srrs_pkg::PS_BLOCKED;
              if (q_empty_r[sem_idx]) begin
                q_head_nxt[sem_idx]  = running_r;
                q_empty_nxt[sem_idx] = 1'b0;
              end else begin
                lk_we = 1'b1;
              end
              q_tail_nxt[sem_idx] = running_r;
              sts.need_scan       = 1'b1;
              halt_on_none_nxt    = 1'b1;
            end
          end
        end
        srrs_pkg::OP_SIGNAL: begin
          if (sem_ok) begin
            if (q_empty_r[sem_idx]) begin
              if (sem_val_r[sem_idx] != CountMax) begin
                sem_val_nxt[sem_idx] = sem_val_r[sem_idx] + COUNT_BITS'(1);
              end
            end else begin
              st_we    = 1'b1;
              st_waddr = head_cur;
              st_wdata = srrs_pkg::PS_ACTIVE;
              if (head_cur == q_tail_r[sem_idx]) begin
                q_empty_nxt[sem_idx] = 1'b1;
              end else begin
                sts.need_link = 1'b1;
              end
            end
          end
        end
        srrs_pkg::OP_TICK: begin
          if (count_r != '0 && !busy_r) begin
            sts.need_scan    = 1'b1;
            halt_on_none_nxt = !cur_ok;
          end
        end
        default: begin
        end
      endcase

      if (sts.need_scan) begin
        iss_s_nxt    = ring_first;
        iss_left_nxt = count_r - CntW'(1);
        chk_v_nxt    = 1'b0;
      end
    end

    if (cmd.scan_step) begin
      sts.scan_done = scan_found || scan_none;
      if (scan_found) begin
        running_nxt = chk_s_r;
        chk_v_nxt   = 1'b0;
      end else if (scan_none) begin
        halt_nxt = halt_r || halt_on_none_r;
      end else if (iss_left_r != '0) begin
        // one slot read issued per cycle, checked the cycle after
        chk_v_nxt    = 1'b1;
        chk_s_nxt    = iss_s_r;
        iss_s_nxt    = iss_s_adv;
        iss_left_nxt = iss_left_r - CntW'(1);
      end else begin
        chk_v_nxt = 1'b0;
      end
    end

    if (cmd.link_load) begin
      q_head_nxt[sem_idx] = lk_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      count_r   <= '0;
      halt_r    <= 1'b0;
      chk_v_r   <= 1'b0;
      for (int i = 0; i < NUM_SEMS; i++) begin
        sem_val_r[i] <= '0;
        q_empty_r[i] <= 1'b1;
      end
    end else begin
      running_r <= running_nxt;
      count_r   <= count_nxt;
      halt_r    <= halt_nxt;
      chk_v_r   <= chk_v_nxt;
      sem_val_r <= sem_val_nxt;
      q_empty_r <= q_empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r           <= op_nxt;
    sid_r          <= sid_nxt;
    ival_r         <= ival_nxt;
    busy_r         <= busy_nxt;
    before_r       <= before_nxt;
    created_r      <= created_nxt;
    full_r         <= full_nxt;
    halt_on_none_r <= halt_on_none_nxt;
    q_head_r       <= q_head_nxt;
    q_tail_r       <= q_tail_nxt;
    iss_s_r        <= iss_s_nxt;
    iss_left_r     <= iss_left_nxt;
    chk_s_r        <= chk_s_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_cur_r     <= 4'({4'b0000, running_r});
      res_sw_r      <= (running_r != before_r);
      res_halt_r    <= halt_r;
      res_created_r <= 4'({4'b0000, created_r});
      res_full_r    <= full_r;
    end
  end

  assign out_current_process = res_cur_r;
  assign out_switched        = res_sw_r;
  assign out_halted          = res_halt_r;
  assign out_created_slot    = res_created_r;
  assign out_table_full      = res_full_r;

endmodule

// ===== rtl/semaphore_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// Flow: an input transfer is followed by execute, then a ring scan for a tick or a
//   blocking wait, or a queue link load for a signal that advances a queue, then finish.
// Items are taken one at a time; the next item is taken while the result waits, and
//   a stalled result holds the following one back.
// Reset (synchronous, rst_n low): clears control state, slot count, halt flag,
//   counts and queue flags at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// semaphore_round_robin_scheduler: process scheduler with counting semaphores
// Round-robin ring of process slots, per-semaphore counts and FIFO wait queues.
// ----------------------------------------------------------------------------
module semaphore_round_robin_scheduler #(
  parameter int NUM_PROCS  = 16,
  parameter int NUM_SEMS   = 4,
  parameter int COUNT_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [1:0] in_sem_id,
  input  logic [7:0] in_init_value,
  input  logic       in_os_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_current_process,
  output logic       out_switched,
  output logic       out_halted,
  output logic [3:0] out_created_slot,
  output logic       out_table_full
);

  srrs_pkg::cmd_t cmd;
  srrs_pkg::sts_t sts;

  srrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  srrs_dp #(
    .NUM_PROCS  (NUM_PROCS),
    .NUM_SEMS   (NUM_SEMS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_operation),
    .in_sem_id           (in_sem_id),
    .in_init_value       (in_init_value),
    .in_os_busy          (in_os_busy),
    .out_current_process (out_current_process),
    .out_switched        (out_switched),
    .out_halted          (out_halted),
    .out_created_slot    (out_created_slot),
    .out_table_full      (out_table_full)
  );

endmodule

// ===== rtl/srrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_props: port-level checks for the scheduler
// Watches the top-level ports and flags ordering and result consistency slips.
// ----------------------------------------------------------------------------
module srrs_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_operation,
  input logic [1:0] in_sem_id,
  input logic [7:0] in_init_value,
  input logic       in_os_busy,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] out_current_process,
  input logic       out_switched,
  input logic       out_halted,
  input logic [3:0] out_created_slot,
  input logic       out_table_full
);

  // reset drops any pending result
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_current_process)
      && $stable(out_switched) && $stable(out_halted)
      && $stable(out_created_slot) && $stable(out_table_full))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_switched && out_created_slot == 4'd0
      && !out_table_full)
    else $error("halted result reports a switch or a create");

  a_full_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_created_slot == 4'd0)
    else $error("refused create reports a slot");

endmodule

bind semaphore_round_robin_scheduler srrs_props u_srrs_props (.*);

// ===== tb/srrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrs_checker: result checker for the semaphore round-robin scheduler
// Watches both channels. On each input transfer it runs the kernel call on its
// own copy of the slot ring and semaphores and queues the report that the call
// must produce. Each output transfer is compared field by field with the oldest
// queued report. It also exports a few state hints for stimulus shaping.
// ----------------------------------------------------------------------------
module srrs_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [1:0] in_sem_id,
  input  logic [7:0] in_init_value,
  input  logic       in_os_busy,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] out_current_process,
  input  logic       out_switched,
  input  logic       out_halted,
  input  logic [3:0] out_created_slot,
  input  logic       out_table_full,
  output int         fault_count,
  output int         reports_owed,
  output int         active_slots,
  output logic [3:0] sem_waiting,
  output logic       sched_halted
);

  localparam int SLOTS = 16;
  localparam int SEMS  = 4;

  typedef struct packed {
    logic [3:0] current;
    logic       switched;
    logic       halted;
    logic [3:0] created;
    logic       full;
  } step_report_t;

  srrs_pkg::pstat_t slot_state [SLOTS];
  int           slot_total;
  logic [3:0]   running;
  logic [3:0]   wait_next  [SLOTS];
  logic [7:0]   sem_count  [SEMS];
  logic [3:0]   q_head     [SEMS];
  logic [3:0]   q_tail     [SEMS];
  logic         q_empty    [SEMS];
  logic         frozen;
  step_report_t step_reports[$];
  int           bad_fields = 0;

  task automatic clear_ring();
    for (int i = 0; i < SLOTS; i++) begin
      slot_state[i] = srrs_pkg::PS_EMPTY;
      wait_next[i]  = '0;
    end
    for (int i = 0; i < SEMS; i++) begin
      sem_count[i] = '0;
      q_head[i]    = '0;
      q_tail[i]    = '0;
      q_empty[i]   = 1'b1;
    end
    slot_total = 0;
    running    = '0;
    frozen     = 1'b0;
    step_reports.delete();
  endtask

  // Next active slot after the running one in ring order, -1 when there is none.
  function automatic int next_ready();
    int s;
    for (int k = 1; k < slot_total; k++) begin
      s = (int'(running) + k) % slot_total;
      if (slot_state[s] == srrs_pkg::PS_ACTIVE) return s;
    end
    return -1;
  endfunction

  function automatic int count_active();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] == srrs_pkg::PS_ACTIVE) n++;
    return n;
  endfunction

  task automatic run_kernel_call(input logic [2:0] op, input logic [1:0] sid,
                                 input logic [7:0] ival, input logic busy);
    logic [3:0]   prev;
    logic [3:0]   h;
    logic         cur_ok;
    int           nx;
    step_report_t r;
    prev   = running;
    r      = '0;
    cur_ok = slot_total != 0 && slot_state[running] == srrs_pkg::PS_ACTIVE;
    if (!frozen) begin
      case (op)
        srrs_pkg::OP_CREATE: begin
          if (slot_total < SLOTS) begin
            slot_state[slot_total] = srrs_pkg::PS_ACTIVE;
            r.created = 4'(slot_total);
            slot_total++;
          end else begin
            r.full = 1'b1;
          end
        end
        srrs_pkg::OP_TERMINATE: begin
          if (cur_ok) slot_state[running] = srrs_pkg::PS_TERM;
        end
        srrs_pkg::OP_SEM_INIT: begin
          sem_count[sid] = ival;
          q_empty[sid]   = 1'b1;
        end
        srrs_pkg::OP_WAIT: begin
          if (sem_count[sid] != 0) begin
            sem_count[sid] = sem_count[sid] - 8'd1;
          end else if (cur_ok) begin
            // block the caller at the queue tail, then hand the CPU on
            slot_state[running] = srrs_pkg::PS_BLOCKED;
            if (q_empty[sid]) begin
              q_head[sid]  = running;
              q_empty[sid] = 1'b0;
            end else begin
              wait_next[q_tail[sid]] = running;
            end
            q_tail[sid] = running;
            nx = next_ready();
            if (nx < 0) frozen = 1'b1;
            else running = 4'(nx);
          end
        end
        srrs_pkg::OP_SIGNAL: begin
          if (q_empty[sid]) begin
            if (sem_count[sid] != 8'hFF) sem_count[sid] = sem_count[sid] + 8'd1;
          end else begin
            h = q_head[sid];
            slot_state[h] = srrs_pkg::PS_ACTIVE;
            if (h == q_tail[sid]) q_empty[sid] = 1'b1;
            else q_head[sid] = wait_next[h];
          end
        end
        srrs_pkg::OP_TICK: begin
          if (slot_total != 0 && !busy) begin
            nx = next_ready();
            if (nx >= 0) running = 4'(nx);
            else if (!cur_ok) frozen = 1'b1;
          end
        end
        default: ;
      endcase
    end
    r.current  = running;
    r.switched = running != prev;
    r.halted   = frozen;
    step_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_fields++;
    end
  endtask

  task automatic check_report();
    step_report_t r;
    if (step_reports.size() == 0) begin
      $error("result transfer with no report pending (current_process %0d)",
             out_current_process);
      bad_fields++;
    end else begin
      r = step_reports.pop_front();
      check_field("current_process", r.current, out_current_process);
      check_field("switched", 4'(r.switched), 4'(out_switched));
      check_field("halted", 4'(r.halted), 4'(out_halted));
      check_field("created_slot", r.created, out_created_slot);
      check_field("table_full", 4'(r.full), 4'(out_table_full));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_ring();
    end else begin
      if (out_valid && !out_stall) check_report();
      if (in_valid && !in_stall)
        run_kernel_call(in_operation, in_sem_id, in_init_value, in_os_busy);
    end
    fault_count  <= bad_fields;
    reports_owed <= step_reports.size();
    active_slots <= count_active();
    sem_waiting  <= {!q_empty[3], !q_empty[2], !q_empty[1], !q_empty[0]};
    sched_halted <= frozen;
  end

endmodule

// ===== tb/tb_semaphore_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_semaphore_round_robin_scheduler: testbench top for the process scheduler
// Drives a directed run through the corner cases of the kernel calls, then
// random calls shaped to keep processes alive while queues fill and drain,
// and finally winds the ring down to a halt. Checking is done by srrs_checker.
// ----------------------------------------------------------------------------
module tb_semaphore_round_robin_scheduler;

  localparam int RANDOM_CALLS = 850;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 40;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [2:0] in_operation  = '0;
  logic [1:0] in_sem_id     = '0;
  logic [7:0] in_init_value = '0;
  logic       in_os_busy    = 1'b0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [3:0] out_current_process;
  logic       out_switched;
  logic       out_halted;
  logic [3:0] out_created_slot;
  logic       out_table_full;

  int         fault_count;
  int         reports_owed;
  int         active_slots;
  logic [3:0] sem_waiting;
  logic       sched_halted;

  int         send_idle_pct = 8;
  int         stall_pct     = 85;
  int         cycle_cnt     = 0;
  int         kill_budget   = 4;
  logic [2:0] last_op       = '0;
  logic [1:0] last_sid      = '0;

  semaphore_round_robin_scheduler u_top (.*);
  srrs_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Leaves valid high after the transfer; the next call or a drain decides it.
  task automatic send_call(input logic [2:0] op, input logic [1:0] sid,
                           input logic [7:0] ival, input logic busy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_sem_id     <= sid;
    in_init_value <= ival;
    in_os_busy    <= busy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_op  = op;
    last_sid = sid;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0) @(posedge clk);
  endtask

  // Hints lag by one call, and one call moves the active count by at most one,
  // so blocking and killing need three active slots to never reach a halt.
  task automatic random_call();
    int         pick;
    logic [1:0] sid;
    logic [7:0] ival;
    logic       busy;
    sid  = 2'($urandom_range(0, 3));
    ival = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 2));
    busy = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      send_call(srrs_pkg::OP_CREATE, sid, ival, busy);
    end else if (pick < 9 && active_slots >= 3 && kill_budget > 0) begin
      kill_budget--;
      send_call(srrs_pkg::OP_TERMINATE, sid, ival, busy);
    end else if (pick < 16) begin
      // don't strand waiters: wake instead of re-initializing a busy queue
      if (sem_waiting[sid] || (last_op == srrs_pkg::OP_WAIT && last_sid == sid))
        send_call(srrs_pkg::OP_SIGNAL, sid, ival, busy);
      else
        send_call(srrs_pkg::OP_SEM_INIT, sid, ival, busy);
    end else if (pick < 44) begin
      if (active_slots >= 3) send_call(srrs_pkg::OP_WAIT, sid, ival, busy);
      else send_call(srrs_pkg::OP_SIGNAL, sid, ival, busy);
    end else if (pick < 70) begin
      send_call(srrs_pkg::OP_SIGNAL, sid, ival, busy);
    end else if (pick < 97) begin
      send_call(srrs_pkg::OP_TICK, sid, ival, busy);
    end else begin
      send_call(3'($urandom_range(6, 7)), sid, ival, busy);
    end
  endtask

  initial begin
    int block_on_sem;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty ring: these must not touch the running slot
    send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_TERMINATE, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_WAIT, 2'd0, 8'd0, 1'b0);
    // count still moves with no process; saturate at the top
    send_call(srrs_pkg::OP_SEM_INIT, 2'd1, 8'hFF, 1'b0);
    send_call(srrs_pkg::OP_WAIT, 2'd1, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_SIGNAL, 2'd1, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_SIGNAL, 2'd1, 8'd0, 1'b1);
    send_call(3'd6, 2'd3, 8'hA5, 1'b1);
    send_call(3'd7, 2'd2, 8'h5A, 1'b0);
    repeat (4) send_call(srrs_pkg::OP_CREATE, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b1);
    send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b0);
    // kill the current slot and keep it with a busy tick
    send_call(srrs_pkg::OP_TERMINATE, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b1);
    send_call(srrs_pkg::OP_TERMINATE, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_WAIT, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b0);
    // two waiters on one semaphore, wake the head, then reset the queue
    send_call(srrs_pkg::OP_WAIT, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_WAIT, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_SIGNAL, 2'd0, 8'd0, 1'b0);
    send_call(srrs_pkg::OP_SEM_INIT, 2'd0, 8'h5A, 1'b0);
    send_call(srrs_pkg::OP_SIGNAL, 2'd0, 8'd0, 1'b0);

    for (int i = 0; i < RANDOM_CALLS; i++) begin
      if (i == 280) begin
        send_idle_pct = 85;
        stall_pct     = 8;
      end
      if (i == 560) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      if (i == 425) drain();
      random_call();
    end

    // wind down to a halt, either by a tick or by a last blocking wait
    block_on_sem = $urandom_range(0, 1);
    drain();
    while (!sched_halted) begin
      if (block_on_sem != 0 && active_slots == 1) begin
        send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b0);
        send_call(srrs_pkg::OP_SEM_INIT, 2'd0, 8'd0, 1'b0);
        send_call(srrs_pkg::OP_WAIT, 2'd0, 8'd0, 1'b0);
      end else begin
        send_call(srrs_pkg::OP_TERMINATE, 2'd0, 8'd0, 1'b0);
        send_call(srrs_pkg::OP_TICK, 2'd0, 8'd0, 1'b0);
      end
      drain();
    end
    // everything is ignored once halted
    for (int op = 0; op < 8; op++)
      send_call(3'(op), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && reports_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/srrs_pkg.sv
rtl/srrs_ram.sv
rtl/srrs_ctrl.sv
rtl/srrs_dp.sv
rtl/semaphore_round_robin_scheduler.sv
rtl/srrs_checker.sv
tb/srrs_checker.sv
tb/tb_semaphore_round_robin_scheduler.sv
